// ----- rtl/block_bitmap_allocator_defines.svh -----
// Assertion shorthands used by the checker of the bitmap allocator.
// Each expects a clock named clk and an active-high reset named rst in scope.
`ifndef BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define BBA_ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/bba_pkg.sv -----
package bba_pkg;

  // bitmap word geometry
  localparam int WORD_W = 32;
  localparam int OFF_W  = 5;

  // field widths
  localparam int BLK_W   = 11;
  localparam int START_W = 10;
  localparam int COUNT_W = 11;
  localparam int KIND_W  = 2;

  // stream widths
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_COUNT = 1'd1;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_USE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

  // result status
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  // result word, last field in the lowest bits
  typedef struct packed {
    logic [BLK_W-1:0]   first_free;
    logic               free_found;
    logic [COUNT_W-1:0] free_count;
    logic               bit_changed;
    logic               status;
  } result_t;

  localparam int OUT_PAD_W = OUT_TDATA_W - $bits(result_t);

  // lowest set bit of a word: {any, index}
  function automatic logic [OFF_W:0] lowest_one(input word_t v);
    logic [OFF_W:0] res;
    res = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        res = {1'b1, OFF_W'(i)};
      end
    end
    return res;
  endfunction

endpackage

// ----- rtl/block_bitmap_allocator.sv -----
// Bitmap free-block allocator. One used/free bit per data block lives in a
// word-wide bitmap RAM (32 blocks per word); a second RAM keeps one "word is
// full" bit per bitmap word, so the lowest free block is found by scanning
// summary words, then reading one bitmap word. After reset a clearing pass
// zeroes both RAMs and holds s_axis_tready low; configuration writes are
// taken at any time but must only be issued while the block is idle. Each
// item is accepted in the idle state, then passes through a read-modify-write
// of the marked bit (in-range marks only), a summary update (only when the
// mark flips the bit), a scan of the summary words (1 at the default size,
// up to ceil(NUM_BLOCKS/1024) in general, none for an empty region), a read
// of one bitmap word (when a word with a free block is found) and the load
// of its result word. s_axis_tready is low from acceptance until the result
// is loaded, so the block does not take a new item before it is through
// with the last; the single read port of each RAM is shared in turn by the
// read-modify-write of the mark and the scan. The result sits in an output
// register, so a finished result may wait on m_axis_tready while the next
// item is accepted.
module block_bitmap_allocator #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // block_number [10:0]
  input  logic [bba_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // kind [1:0]
  input  logic [bba_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status [0], bit_changed [1], free_count [12:2], free_found [13],
  // first_free [24:14]
  output logic [bba_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int WORD_W  = bba_pkg::WORD_W;
  localparam int OFF_W   = bba_pkg::OFF_W;
  localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
  localparam int EXT_W   = (CNT_W > bba_pkg::COUNT_W) ? CNT_W : bba_pkg::COUNT_W;
  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int NUM_SUM   = (NUM_WORDS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SADDR_W = (NUM_SUM > 1) ? $clog2(NUM_SUM) : 1;
  // linear block index = {summary address, word in summary, bit in word}
  localparam int WSEL_W  = SADDR_W + OFF_W;
  localparam int LIN_W   = WSEL_W + OFF_W;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_MARK   = 3'd2;
  localparam logic [2:0] ST_SUMUPD = 3'd3;
  localparam logic [2:0] ST_SCAN0  = 3'd4;
  localparam logic [2:0] ST_SCAN   = 3'd5;
  localparam logic [2:0] ST_FINE   = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  // configuration registers
  logic [bba_pkg::START_W-1:0] region_base;
  logic [bba_pkg::COUNT_W-1:0] data_count;

  // control
  logic [2:0]         state;
  logic [WADDR_W-1:0] clr_cnt;
  logic [CNT_W-1:0]   used_count;

  // per-item working registers
  logic               status;
  logic               is_use;
  logic               changed;
  logic               full_new;
  logic               found;
  logic [LIN_W-1:0]   lin;
  logic [SADDR_W-1:0] scan_s;
  logic [WSEL_W-1:0]  cand_w;

  // output register
  logic               m_valid;
  bba_pkg::result_t   m_data;

  // bitmap RAM
  bba_pkg::word_t     dmem [NUM_WORDS];
  logic               d_we;
  logic [WADDR_W-1:0] d_waddr;
  logic [WADDR_W-1:0] d_raddr;
  bba_pkg::word_t     d_wdata;
  bba_pkg::word_t     d_rdata;

  // word-full summary RAM
  bba_pkg::word_t     smem [NUM_SUM];
  logic               s_we;
  logic [SADDR_W-1:0] s_waddr;
  logic [SADDR_W-1:0] s_raddr;
  bba_pkg::word_t     s_wdata;
  bba_pkg::word_t     s_rdata;

  // input decode
  logic [bba_pkg::KIND_W-1:0] kind;
  logic [EXT_W-1:0]   blk_ext;
  logic [EXT_W-1:0]   start_ext;
  logic [EXT_W-1:0]   off_ext;
  logic [EXT_W-1:0]   size_ext;
  logic [EXT_W-1:0]   last_ext;
  logic [LIN_W-1:0]   last_idx;
  logic [LIN_W-1:0]   in_lin;
  logic               in_range;
  logic               is_mark;
  logic               size_zero;
  logic               s_fire;
  logic               out_free;
  logic               clr_in_sum;

  // modify / search
  bba_pkg::word_t     mark_word;
  logic               mark_flip;
  bba_pkg::word_t     sum_word;
  bba_pkg::word_t     scan_avail;
  bba_pkg::word_t     fine_avail;
  logic [OFF_W:0]     scan_pick;
  logic [OFF_W:0]     fine_pick;
  logic               last_sum;
  logic               last_word;
  logic [WSEL_W-1:0]  cand_next;

  // result
  logic [EXT_W-1:0]   used_ext;
  logic [EXT_W-1:0]   free_ext;
  logic [EXT_W-1:0]   first_ext;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {{bba_pkg::OUT_PAD_W{1'b0}}, m_data};
  assign out_free      = !m_valid || m_axis_tready;

  assign kind      = s_axis_tuser[bba_pkg::KIND_W-1:0];
  assign is_mark   = (kind == bba_pkg::KIND_USE) || (kind == bba_pkg::KIND_FREE);
  assign blk_ext   = EXT_W'(s_axis_tdata[bba_pkg::BLK_W-1:0]);
  assign start_ext = EXT_W'(region_base);
  assign off_ext   = blk_ext - start_ext;
  // region holds min(data_count, NUM_BLOCKS) blocks
  assign size_ext  = (EXT_W'(data_count) < EXT_W'(NUM_BLOCKS)) ?
                     EXT_W'(data_count) : EXT_W'(NUM_BLOCKS);
  assign size_zero = (size_ext == '0);
  assign last_ext  = size_ext - EXT_W'(1);
  assign last_idx  = last_ext[LIN_W-1:0];
  assign in_range  = (blk_ext >= start_ext) && (off_ext < size_ext);
  assign in_lin    = off_ext[LIN_W-1:0];
  assign clr_in_sum = ({1'b0, clr_cnt} < (WADDR_W + 1)'(NUM_SUM));

  // read-modify-write of the marked bit, summary bit update, and the search
  always_comb begin
    mark_word = d_rdata;
    mark_word[lin[OFF_W-1:0]] = is_use;
    mark_flip = (d_rdata[lin[OFF_W-1:0]] != is_use);

    sum_word = s_rdata;
    sum_word[lin[2*OFF_W-1:OFF_W]] = full_new;

    // words past the end of the region count as full
    last_sum = (scan_s == last_idx[LIN_W-1:2*OFF_W]);
    for (int j = 0; j < WORD_W; j++) begin
      scan_avail[j] = !s_rdata[j] &&
                      (!last_sum || (OFF_W'(j) <= last_idx[2*OFF_W-1:OFF_W]));
    end
    scan_pick = bba_pkg::lowest_one(scan_avail);
    cand_next = {scan_s, scan_pick[OFF_W-1:0]};

    // bits past the end of the region count as used
    last_word = (cand_w == last_idx[LIN_W-1:OFF_W]);
    for (int b = 0; b < WORD_W; b++) begin
      fine_avail[b] = !d_rdata[b] &&
                      (!last_word || (OFF_W'(b) <= last_idx[OFF_W-1:0]));
    end
    fine_pick = bba_pkg::lowest_one(fine_avail);

    used_ext  = EXT_W'(used_count);
    free_ext  = (size_ext > used_ext) ? (size_ext - used_ext) : '0;
    first_ext = start_ext + EXT_W'(lin);
  end

  // RAM port control
  always_comb begin
    d_we    = 1'b0;
    d_waddr = lin[OFF_W+WADDR_W-1:OFF_W];
    d_wdata = mark_word;
    d_raddr = lin[OFF_W+WADDR_W-1:OFF_W];
    s_we    = 1'b0;
    s_waddr = lin[LIN_W-1:2*OFF_W];
    s_wdata = sum_word;
    s_raddr = lin[LIN_W-1:2*OFF_W];
    unique case (state)
      ST_CLEAR: begin
        d_we    = 1'b1;
        d_waddr = clr_cnt;
        d_wdata = '0;
        s_we    = clr_in_sum;
        s_waddr = clr_cnt[SADDR_W-1:0];
        s_wdata = '0;
      end
      ST_IDLE: begin
        d_raddr = in_lin[OFF_W+WADDR_W-1:OFF_W];
      end
      ST_MARK: begin
        d_we = mark_flip;
      end
      ST_SUMUPD: begin
        s_we = 1'b1;
      end
      ST_SCAN0: begin
        s_raddr = '0;
      end
      ST_SCAN: begin
        // prefetch the next summary word; stop at the last one in the region
        s_raddr = last_sum ? scan_s : (scan_s + SADDR_W'(1));
        d_raddr = cand_next[WADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem[d_waddr] <= d_wdata;
    end
    d_rdata <= dmem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    s_rdata <= smem[s_raddr];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      data_count  <= bba_pkg::COUNT_W'(1024);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bba_pkg::REG_DATA_START: region_base <= cfg_data[bba_pkg::START_W-1:0];
        bba_pkg::REG_DATA_COUNT: data_count <= cfg_data;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      used_count <= '0;
      m_valid    <= 1'b0;
    end else begin
      // a word loaded in ST_DONE replaces the one leaving
      if (m_valid && m_axis_tready && (state != ST_DONE)) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + WADDR_W'(1);
          if (clr_cnt == WADDR_W'(NUM_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_fire) begin
            status  <= (is_mark && !in_range) ? bba_pkg::STATUS_RANGE
                                              : bba_pkg::STATUS_OK;
            is_use  <= (kind == bba_pkg::KIND_USE);
            lin     <= in_lin;
            changed <= 1'b0;
            state   <= (is_mark && in_range) ? ST_MARK : ST_SCAN0;
          end
        end
        ST_MARK: begin
          changed  <= mark_flip;
          full_new <= &mark_word;
          if (mark_flip) begin
            if (is_use) begin
              used_count <= used_count + CNT_W'(1);
            end else if (used_count != '0) begin
              used_count <= used_count - CNT_W'(1);
            end
            state <= ST_SUMUPD;
          end else begin
            state <= ST_SCAN0;
          end
        end
        ST_SUMUPD: begin
          state <= ST_SCAN0;
        end
        ST_SCAN0: begin
          scan_s <= '0;
          if (size_zero) begin
            found <= 1'b0;
            state <= ST_DONE;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_pick[OFF_W]) begin
            cand_w <= cand_next;
            state  <= ST_FINE;
          end else if (last_sum) begin
            found <= 1'b0;
            state <= ST_DONE;
          end else begin
            scan_s <= scan_s + SADDR_W'(1);
          end
        end
        ST_FINE: begin
          found <= fine_pick[OFF_W];
          lin   <= {cand_w, fine_pick[OFF_W-1:0]};
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register frees up
          if (out_free) begin
            m_valid            <= 1'b1;
            m_data.status      <= status;
            m_data.bit_changed <= changed;
            m_data.free_count  <= free_ext[bba_pkg::COUNT_W-1:0];
            m_data.free_found  <= found;
            m_data.first_free  <= found ? first_ext[bba_pkg::BLK_W-1:0] : '0;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/bba_checker.sv -----
`include "block_bitmap_allocator_defines.svh"

module bba_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bba_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic             in_fire;
  logic             out_fire;
  logic [1:0]       pending;
  bba_pkg::result_t res;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign res      = m_axis_tdata[$bits(bba_pkg::result_t)-1:0];

  // words accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_fire) - 2'(out_fire);
    end
  end

  `BBA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
  `BBA_ASSERT_IMPLY(a_out_has_item, m_axis_tvalid, pending != 2'd0, "result word with no item outstanding")
  `BBA_ASSERT_IMPLY(a_refused_no_change, m_axis_tvalid && res.status, !res.bit_changed, "refused mark reports a changed bit")
  `BBA_ASSERT_IMPLY(a_none_free_zero, m_axis_tvalid && !res.free_found, res.first_free == '0, "first_free not zero with nothing free")

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (.*);

// ----- bench/tb_block_bitmap_allocator.sv -----
`timescale 1ns / 100ps

module tb_block_bitmap_allocator;

  localparam int NUM_BLOCKS = 1024;
  // Kind 3 has no name in the package; the block treats it as a query.
  localparam logic [bba_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
  // Settle time after draining, with margin over the longest item at this size.
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int NUM_PHASES = 10;
  localparam int PRESSURE_PHASE = 4;

  typedef enum logic {ROW_ITEM, ROW_REG} row_op_t;

  typedef struct {
    row_op_t                        op;
    logic [bba_pkg::KIND_W-1:0]     kind;
    logic [bba_pkg::CFG_DATA_W-1:0] value;
    logic [bba_pkg::CFG_IDX_W-1:0]  reg_idx;
    bit                             typed;
    bba_pkg::result_t               res;
  } stim_row_t;

  typedef struct {
    int region_start;
    int region_count;
    int gap_pct;
    int stall_pct;
    int use_pct;
    int items;
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // block_number [10:0], zero padded
  logic [bba_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  // kind [1:0]
  logic [bba_pkg::IN_TUSER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // status [0], bit_changed [1], free_count [12:2], free_found [13],
  // first_free [24:14]
  logic [bba_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Typed expectation that travels beside the word on the input side.
  bit typed_flag = 1'b0;
  bba_pkg::result_t typed_res = '0;

  // Shadow of the allocator: bitmap, used count and region registers.
  bit used_map [NUM_BLOCKS];
  int used_total = 0;
  int cfg_start = 0;
  int cfg_count = 1024;

  bba_pkg::result_t pending_results[$];
  bba_pkg::result_t seen_res, due_res;
  int errors = 0;
  int cycles = 0;

  // Idling controls, set by the main sequence.
  int gap_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  stim_row_t directed_rows[$];
  phase_t phase_plan [NUM_PHASES];

  block_bitmap_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Abort on a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Apply one item to the shadow bitmap and return the result word it owes.
  function automatic bba_pkg::result_t allocate_step(
      input logic [bba_pkg::KIND_W-1:0] k, input logic [bba_pkg::BLK_W-1:0] blk);
    bba_pkg::result_t r;
    int span;
    int b;
    int idx;
    r = '0;
    r.status = bba_pkg::STATUS_OK;
    b = blk;
    // Saturate the region at the bitmap size.
    span = (cfg_count < NUM_BLOCKS) ? cfg_count : NUM_BLOCKS;
    if (k == bba_pkg::KIND_USE || k == bba_pkg::KIND_FREE) begin
      if (b < cfg_start || b - cfg_start >= span) begin
        r.status = bba_pkg::STATUS_RANGE;
      end else begin
        idx = b - cfg_start;
        if (k == bba_pkg::KIND_USE && !used_map[idx]) begin
          used_map[idx] = 1'b1;
          used_total++;
          r.bit_changed = 1'b1;
        end else if (k == bba_pkg::KIND_FREE && used_map[idx]) begin
          used_map[idx] = 1'b0;
          if (used_total > 0) used_total--;
          r.bit_changed = 1'b1;
        end
      end
    end
    // Bits left behind a shrunk region still count as used.
    r.free_count = bba_pkg::COUNT_W'((span > used_total) ? span - used_total : 0);
    for (int i = 0; i < span; i++) begin
      if (!used_map[i]) begin
        r.free_found = 1'b1;
        r.first_free = bba_pkg::BLK_W'(cfg_start + i);
        break;
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Sample every handshake at the rising edge: register writes, accepted
  // input words and delivered result words.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bba_pkg::REG_DATA_START) begin
          cfg_start = int'(cfg_data[bba_pkg::START_W-1:0]);
        end else if (cfg_index == bba_pkg::REG_DATA_COUNT) begin
          cfg_count = int'(cfg_data);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        due_res = allocate_step(s_axis_tuser, s_axis_tdata[bba_pkg::BLK_W-1:0]);
        // Typed rows override the shadow's answer but still advance it.
        if (typed_flag) due_res = typed_res;
        pending_results.insert(pending_results.size(), due_res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen_res = bba_pkg::result_t'(m_axis_tdata[$bits(bba_pkg::result_t)-1:0]);
        if (pending_results.size() == 0) begin
          $display("%0t: result word with nothing expected, expected none, got %h",
                   $time, m_axis_tdata);
          errors++;
        end else begin
          due_res = pending_results.pop_front();
          check_field("status", due_res.status, seen_res.status);
          check_field("bit_changed", due_res.bit_changed, seen_res.bit_changed);
          check_field("free_count", due_res.free_count, seen_res.free_count);
          check_field("free_found", due_res.free_found, seen_res.free_found);
          check_field("first_free", due_res.first_free, seen_res.first_free);
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one word. Enter at the falling edge right after the previous
  // acceptance (or while idle) and return at the falling edge after this one
  // is taken, so tvalid is only lowered or reloaded at falling edges.
  task automatic send_word(input logic [bba_pkg::KIND_W-1:0] k,
                           input logic [bba_pkg::BLK_W-1:0] b,
                           input bit typed, input bba_pkg::result_t e);
    int gap;
    gap = 0;
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= k;
    s_axis_tdata <= bba_pkg::IN_TDATA_W'(b);
    typed_flag <= typed;
    typed_res <= e;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop tvalid, wait for every owed result, then let the block settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bba_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bba_pkg::CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pick a random item for the current region, mostly in-region marks.
  task automatic pick_item(input int use_pct, output logic [bba_pkg::KIND_W-1:0] k,
                           output logic [bba_pkg::BLK_W-1:0] b);
    int r;
    int span;
    int lim;
    int off;
    r = $urandom_range(99);
    span = (cfg_count < NUM_BLOCKS) ? cfg_count : NUM_BLOCKS;
    b = bba_pkg::BLK_W'($urandom);
    if (r < 8) begin
      k = bba_pkg::KIND_QUERY;
    end else if (r < 12) begin
      k = KIND_SPARE;
    end else begin
      k = ($urandom_range(99) < use_pct) ? bba_pkg::KIND_USE : bba_pkg::KIND_FREE;
      if (r < 22 || span == 0) begin
        // keep the random block number: mostly outside small regions
      end else if (r < 28) begin
        // hit both region edges and one past each
        case ($urandom_range(3))
          0: b = bba_pkg::BLK_W'(cfg_start - 1);
          1: b = bba_pkg::BLK_W'(cfg_start);
          2: b = bba_pkg::BLK_W'(cfg_start + span - 1);
          default: b = bba_pkg::BLK_W'(cfg_start + span);
        endcase
      end else begin
        // crowd the low end so the region fills and first_free walks up
        lim = (span < 40) ? span : 40;
        off = ($urandom_range(9) < 7) ? $urandom_range(lim - 1) : $urandom_range(span - 1);
        b = bba_pkg::BLK_W'(cfg_start + off);
      end
    end
  endtask

  function automatic stim_row_t item_row(input logic [bba_pkg::KIND_W-1:0] k, input int b);
    stim_row_t row;
    row = '{op: ROW_ITEM, kind: k, value: bba_pkg::CFG_DATA_W'(b), reg_idx: '0,
            typed: 1'b0, res: '0};
    return row;
  endfunction

  function automatic stim_row_t typed_row(input logic [bba_pkg::KIND_W-1:0] k, input int b,
                                          input logic st, input logic ch, input int fc,
                                          input logic ff, input int first);
    stim_row_t row;
    row = item_row(k, b);
    row.typed = 1'b1;
    row.res.status = st;
    row.res.bit_changed = ch;
    row.res.free_count = bba_pkg::COUNT_W'(fc);
    row.res.free_found = ff;
    row.res.first_free = bba_pkg::BLK_W'(first);
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [bba_pkg::CFG_IDX_W-1:0] idx,
                                        input int val);
    stim_row_t row;
    row = item_row(bba_pkg::KIND_QUERY, val);
    row.op = ROW_REG;
    row.reg_idx = idx;
    return row;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input stim_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  initial begin
    logic [bba_pkg::KIND_W-1:0] k;
    logic [bba_pkg::BLK_W-1:0] b;
    stim_row_t row;

    // Directed table: full region, then shrink, move and empty it.
    add_row(typed_row(bba_pkg::KIND_QUERY, 0, bba_pkg::STATUS_OK, 0, 1024, 1, 0));
    add_row(typed_row(bba_pkg::KIND_USE, 0, bba_pkg::STATUS_OK, 1, 1023, 1, 1));
    // repeat mark used
    add_row(typed_row(bba_pkg::KIND_USE, 0, bba_pkg::STATUS_OK, 0, 1023, 1, 1));
    add_row(typed_row(bba_pkg::KIND_USE, 2047, bba_pkg::STATUS_RANGE, 0, 1023, 1, 1));
    add_row(typed_row(bba_pkg::KIND_FREE, 2047, bba_pkg::STATUS_RANGE, 0, 1023, 1, 1));
    // spare kind acts as a query
    add_row(typed_row(KIND_SPARE, 2047, bba_pkg::STATUS_OK, 0, 1023, 1, 1));
    add_row(typed_row(bba_pkg::KIND_USE, 1023, bba_pkg::STATUS_OK, 1, 1022, 1, 1));
    // repeat mark free
    add_row(typed_row(bba_pkg::KIND_FREE, 1, bba_pkg::STATUS_OK, 0, 1022, 1, 1));
    add_row(item_row(bba_pkg::KIND_QUERY, 1234));
    // shrink to two blocks: free count saturates at zero
    add_row(reg_row(bba_pkg::REG_DATA_COUNT, 2));
    add_row(typed_row(bba_pkg::KIND_QUERY, 0, bba_pkg::STATUS_OK, 0, 0, 1, 1));
    // last free block taken: nothing free
    add_row(typed_row(bba_pkg::KIND_USE, 1, bba_pkg::STATUS_OK, 1, 0, 0, 0));
    add_row(typed_row(bba_pkg::KIND_USE, 2, bba_pkg::STATUS_RANGE, 0, 0, 0, 0));
    // move the region to the top start; bits stay by position
    add_row(reg_row(bba_pkg::REG_DATA_START, 1023));
    add_row(typed_row(bba_pkg::KIND_QUERY, 5, bba_pkg::STATUS_OK, 0, 0, 0, 0));
    add_row(typed_row(bba_pkg::KIND_FREE, 1024, bba_pkg::STATUS_OK, 1, 0, 1, 1024));
    add_row(typed_row(bba_pkg::KIND_FREE, 1022, bba_pkg::STATUS_RANGE, 0, 0, 1, 1024));
    // empty region refuses every mark
    add_row(reg_row(bba_pkg::REG_DATA_COUNT, 0));
    add_row(typed_row(bba_pkg::KIND_QUERY, 0, bba_pkg::STATUS_OK, 0, 0, 0, 0));
    add_row(typed_row(bba_pkg::KIND_USE, 1023, bba_pkg::STATUS_RANGE, 0, 0, 0, 0));
    add_row(reg_row(bba_pkg::REG_DATA_START, 0));
    add_row(reg_row(bba_pkg::REG_DATA_COUNT, 1024));
    add_row(item_row(bba_pkg::KIND_FREE, 0));
    add_row(item_row(bba_pkg::KIND_FREE, 1023));
    add_row(item_row(bba_pkg::KIND_QUERY, 0));

    // start, count, sender gap %, receiver stall %, mark-used %, items
    phase_plan = '{
      '{0, 1024, 0, 0, 70, 300},
      '{5, 37, 45, 0, 60, 175},
      '{1023, 1024, 0, 45, 65, 175},
      '{0, 1, 22, 22, 50, 175},
      '{300, 64, 0, 0, 60, 175},
      '{0, 0, 45, 0, 60, 175},
      '{990, 70, 0, 45, 40, 175},
      '{0, 0, 22, 22, 50, 50},
      '{31, 33, 0, 0, 60, 175},
      '{0, 0, 22, 22, 55, 175}
    };
    phase_plan[5].region_start = $urandom_range(1023);
    phase_plan[5].region_count = $urandom_range(1024);
    phase_plan[9].region_start = $urandom_range(1023);
    phase_plan[9].region_count = $urandom_range(48, 1);

    // Hold reset, then release it away from the sampling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table with no idling on either side.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.op == ROW_REG) write_reg(row.reg_idx, row.value);
      else send_word(row.kind, row.value[bba_pkg::BLK_W-1:0], row.typed, row.res);
    end

    // Random phases, each with its own region and idling mix.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(bba_pkg::REG_DATA_START, bba_pkg::CFG_DATA_W'(phase_plan[p].region_start));
      write_reg(bba_pkg::REG_DATA_COUNT, bba_pkg::CFG_DATA_W'(phase_plan[p].region_count));
      gap_pct = phase_plan[p].gap_pct;
      stall_pct = phase_plan[p].stall_pct;
      for (int n = 0; n < phase_plan[p].items; n++) begin
        if (p == PRESSURE_PHASE) begin
          // Block the output for a long stretch while words keep coming.
          if (n == 20) hold_req = 1'b1;
          // Pause the sender until all results are back.
          if (n == 120) wait_drained();
        end
        pick_item(phase_plan[p].use_pct, k, b);
        send_word(k, b, 1'b0, '0);
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
